### rtl/i2cms_pkg.sv
// ----------------------------------------------------------------------------
// i2cms_pkg
// Shared constants and codes for the I2C master bit sequencer.
// ----------------------------------------------------------------------------
package i2cms_pkg;

	localparam int HALF_COUNT_WIDTH_DEF = 16;
	localparam int HALF_PERIOD_W        = 16;
	localparam logic [HALF_PERIOD_W-1:0] HALF_PERIOD_RST = 16'd500;

	localparam int CMD_W   = 3;
	localparam int ADDR_W  = 7;
	localparam int BYTE_W  = 8;
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	typedef enum logic [CMD_W-1:0] {
		ACT_NONE  = 3'd0,
		ACT_BEGIN = 3'd1,
		ACT_WRITE = 3'd2,
		ACT_READ  = 3'd3,
		ACT_STOP  = 3'd4
	} action_t;

	// register index, taken from paddr[2]
	typedef enum logic {
		REG_HALF_PERIOD = 1'b0,
		REG_NONE        = 1'b1
	} reg_idx_t;

	localparam int FLAG_NACK  = 0;
	localparam int FLAG_ABORT = 1;
	localparam int FLAG_OPT   = 2;

endpackage

### rtl/i2c_master_bit_sequencer.sv
// ----------------------------------------------------------------------------
// i2c_master_bit_sequencer
// Each result is registered on the clock edge that accepts its tick.
// Throughput: one tick per cycle; a tick is taken while the previous result
// is being collected, so only a stalled full result register holds input off.
// Reset (arst_n low): bus free, sequencer idle, shift registers and flags
// cleared, half period back to 500 ticks.
// ----------------------------------------------------------------------------
// I2C master bit sequencer with 7-bit addressing. Each tick may carry a
// command and carries the sampled SDA level; the sequencer drives open-drain
// SCL and SDA in half-period segments and reports status per tick.
// ----------------------------------------------------------------------------
module i2c_master_bit_sequencer #(
	parameter int HALF_COUNT_WIDTH = i2cms_pkg::HALF_COUNT_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,

	input  logic                              item_valid,
	output logic                              item_stall,
	input  logic [i2cms_pkg::CMD_W-1:0]       action,
	input  logic [i2cms_pkg::ADDR_W-1:0]      dev_addr,
	input  logic                              read_dir,
	input  logic                              no_start,
	input  logic                              ignore_nak,
	input  logic [i2cms_pkg::BYTE_W-1:0]      wdata,
	input  logic                              send_nack,
	input  logic                              sda_in,

	output logic                              res_valid,
	input  logic                              res_stall,
	output logic                              scl_low,
	output logic                              sda_low,
	output logic                              busy_res,
	output logic                              done_res,
	output logic                              nack_seen,
	output logic                              aborted,
	output logic [i2cms_pkg::BYTE_W-1:0]      rx_data,

	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [i2cms_pkg::PADDR_W-1:0]     paddr,
	input  logic [i2cms_pkg::PDATA_W-1:0]     pwdata,
	output logic [i2cms_pkg::PDATA_W-1:0]     prdata,
	output logic                              pready
);
	import i2cms_pkg::*;

	typedef enum logic [4:0] {
		PH_IDLE,
		PH_ST_A, PH_ST_B, PH_ST_C,
		PH_RS_A, PH_RS_B, PH_RS_C, PH_RS_D,
		PH_WB_A, PH_WB_B, PH_WB_C,
		PH_WA_A, PH_WA_B, PH_WA_C,
		PH_RB_A, PH_RB_B, PH_RB_C,
		PH_RA_A, PH_RA_B, PH_RA_C,
		PH_SP_A, PH_SP_B, PH_SP_C
	} phase_t;

	logic [HALF_PERIOD_W-1:0]    half_period_q;
	phase_t                      phase_q, phase_d;
	logic                        bus_held_q, bus_held_d;
	logic [2:0]                  bit_idx_q, bit_idx_d;
	logic [HALF_COUNT_WIDTH-1:0] cnt_q, cnt_d;
	logic [BYTE_W-1:0]           tx_q, tx_d;
	logic [BYTE_W-1:0]           rx_q, rx_d;
	logic [2:0]                  flags_q, flags_d;

	logic                        take;
	logic                        cfg_wr;
	logic [HALF_COUNT_WIDTH-1:0] limit;
	logic [HALF_COUNT_WIDTH:0]   cnt_inc;
	logic                        seg_end;
	logic                        scl_d, sda_d, done_d;
	logic                        tx_bit, ack_drv;

	assign pready     = 1'b1;
	assign cfg_wr     = psel && penable && pwrite && pready;
	assign item_stall = res_valid && res_stall;
	assign take       = item_valid && !item_stall;

	always_comb begin
		prdata = '0;
		if (reg_idx_t'(paddr[2]) == REG_HALF_PERIOD) begin
			prdata = {{(PDATA_W-HALF_PERIOD_W){1'b0}}, half_period_q};
		end
	end

	always_comb begin
		limit = HALF_COUNT_WIDTH'(half_period_q);
		if (limit == '0) begin
			limit = HALF_COUNT_WIDTH'(1);
		end
	end

	always_comb begin
		phase_d    = phase_q;
		bus_held_d = bus_held_q;
		bit_idx_d  = bit_idx_q;
		cnt_d      = cnt_q;
		tx_d       = tx_q;
		rx_d       = rx_q;
		flags_d    = flags_q;
		done_d     = 1'b0;
		scl_d      = 1'b0;
		sda_d      = 1'b0;

		// command launch from idle
		if (phase_q == PH_IDLE) begin
			case (action)
				ACT_BEGIN: begin
					tx_d       = {dev_addr, read_dir};
					flags_d    = {ignore_nak, 2'b00};
					bit_idx_d  = 3'd7;
					cnt_d      = '0;
					bus_held_d = 1'b1;
					if (!bus_held_q) begin
						phase_d = PH_ST_A;
					end else if (no_start) begin
						phase_d = PH_WB_A;
					end else begin
						phase_d = PH_RS_A;
					end
				end
				ACT_WRITE: begin
					if (bus_held_q) begin
						tx_d      = wdata;
						flags_d   = {ignore_nak, 2'b00};
						bit_idx_d = 3'd7;
						cnt_d     = '0;
						phase_d   = PH_WB_A;
					end
				end
				ACT_READ: begin
					if (bus_held_q) begin
						rx_d      = '0;
						flags_d   = {send_nack, 2'b00};
						bit_idx_d = 3'd7;
						cnt_d     = '0;
						phase_d   = PH_RB_A;
					end
				end
				ACT_STOP: begin
					if (bus_held_q) begin
						flags_d = '0;
						cnt_d   = '0;
						phase_d = PH_SP_A;
					end
				end
				default: ;
			endcase
		end

		// line drive of the segment in progress
		tx_bit  = tx_d[bit_idx_d];
		ack_drv = !flags_d[FLAG_OPT];
		unique case (phase_d) inside
			PH_ST_A, PH_RS_B, PH_WA_B, PH_RB_B, PH_SP_C: begin
				scl_d = 1'b0; sda_d = 1'b0;
			end
			PH_ST_B, PH_RS_C, PH_SP_B: begin
				scl_d = 1'b0; sda_d = 1'b1;
			end
			PH_ST_C, PH_RS_D, PH_SP_A: begin
				scl_d = 1'b1; sda_d = 1'b1;
			end
			PH_RS_A, PH_WA_A, PH_WA_C, PH_RB_A, PH_RB_C: begin
				scl_d = 1'b1; sda_d = 1'b0;
			end
			PH_WB_A, PH_WB_C: begin
				scl_d = 1'b1; sda_d = !tx_bit;
			end
			PH_WB_B: begin
				scl_d = 1'b0; sda_d = !tx_bit;
			end
			PH_RA_A, PH_RA_C: begin
				scl_d = 1'b1; sda_d = ack_drv;
			end
			PH_RA_B: begin
				scl_d = 1'b0; sda_d = ack_drv;
			end
			default: begin
				scl_d = bus_held_d; sda_d = 1'b0;
			end
		endcase

		// half-period timing and segment advance
		cnt_inc = {1'b0, cnt_d} + {{HALF_COUNT_WIDTH{1'b0}}, 1'b1};
		seg_end = cnt_inc >= {1'b0, limit};
		if (phase_d != PH_IDLE) begin
			if (seg_end) begin
				cnt_d = '0;
				unique case (phase_d) inside
					PH_ST_A: phase_d = PH_ST_B;
					PH_ST_B: phase_d = PH_ST_C;
					PH_RS_A: phase_d = PH_RS_B;
					PH_RS_B: phase_d = PH_RS_C;
					PH_RS_C: phase_d = PH_RS_D;
					PH_ST_C, PH_RS_D: begin
						bit_idx_d = 3'd7;
						phase_d   = PH_WB_A;
					end
					PH_WB_A: phase_d = PH_WB_B;
					PH_WB_B: phase_d = PH_WB_C;
					PH_WB_C: begin
						if (bit_idx_d == 3'd0) begin
							phase_d = PH_WA_A;
						end else begin
							bit_idx_d = bit_idx_d - 3'd1;
							phase_d   = PH_WB_A;
						end
					end
					PH_WA_A: phase_d = PH_WA_B;
					PH_WA_B: begin
						if (sda_in) begin
							flags_d[FLAG_NACK] = 1'b1;
						end
						phase_d = PH_WA_C;
					end
					PH_WA_C: begin
						if (flags_d[FLAG_NACK] && !flags_d[FLAG_OPT]) begin
							flags_d[FLAG_ABORT] = 1'b1;
							phase_d = PH_SP_A;
						end else begin
							phase_d = PH_IDLE;
							done_d  = 1'b1;
						end
					end
					PH_RB_A: phase_d = PH_RB_B;
					PH_RB_B: begin
						rx_d    = {rx_d[BYTE_W-2:0], sda_in};
						phase_d = PH_RB_C;
					end
					PH_RB_C: begin
						if (bit_idx_d == 3'd0) begin
							phase_d = PH_RA_A;
						end else begin
							bit_idx_d = bit_idx_d - 3'd1;
							phase_d   = PH_RB_A;
						end
					end
					PH_RA_A: phase_d = PH_RA_B;
					PH_RA_B: phase_d = PH_RA_C;
					PH_RA_C: begin
						phase_d = PH_IDLE;
						done_d  = 1'b1;
					end
					PH_SP_A: phase_d = PH_SP_B;
					PH_SP_B: phase_d = PH_SP_C;
					PH_SP_C: begin
						bus_held_d = 1'b0;
						phase_d    = PH_IDLE;
						done_d     = 1'b1;
					end
					default: phase_d = PH_IDLE;
				endcase
			end else begin
				cnt_d = cnt_inc[HALF_COUNT_WIDTH-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_period_q <= HALF_PERIOD_RST;
			phase_q       <= PH_IDLE;
			bus_held_q    <= 1'b0;
			bit_idx_q     <= '0;
			cnt_q         <= '0;
			tx_q          <= '0;
			rx_q          <= '0;
			flags_q       <= '0;
			res_valid     <= 1'b0;
			scl_low       <= 1'b0;
			sda_low       <= 1'b0;
			busy_res      <= 1'b0;
			done_res      <= 1'b0;
		end else begin
			if (cfg_wr && reg_idx_t'(paddr[2]) == REG_HALF_PERIOD) begin
				half_period_q <= pwdata[HALF_PERIOD_W-1:0];
			end
			if (take) begin
				phase_q    <= phase_d;
				bus_held_q <= bus_held_d;
				bit_idx_q  <= bit_idx_d;
				cnt_q      <= cnt_d;
				tx_q       <= tx_d;
				rx_q       <= rx_d;
				flags_q    <= flags_d;
				res_valid  <= 1'b1;
				scl_low    <= scl_d;
				sda_low    <= sda_d;
				busy_res   <= (phase_d != PH_IDLE);
				done_res   <= done_d;
			end else if (!res_stall) begin
				res_valid <= 1'b0;
			end
		end
	end

	assign nack_seen = flags_q[FLAG_NACK];
	assign aborted   = flags_q[FLAG_ABORT];
	assign rx_data   = rx_q;

	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && done_res |-> !busy_res)
		else $error("done reported while still busy");

	a_abort_has_nack: assert property (@(posedge clk) disable iff (!arst_n)
		aborted |-> nack_seen)
		else $error("abort flagged without a NACK");

	a_abort_frees_bus: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && done_res && aborted |-> !bus_held_q)
		else $error("aborted command left the bus held");

	a_idle_count_clear: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_IDLE |-> cnt_q == '0)
		else $error("half-period counter running while idle");

endmodule
